@@ rtl/urde_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urde_pkg
// Types, codes and the CRC-8 step shared by the register datagram engine.
// ----------------------------------------------------------------------------
package urde_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_RX    = 2'd2;

   // Result codes carried in result_kind.
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_RESULT = 1'b1;

   // Configuration register map (index is byte address / 4).
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_SLAVE    = 1'b0;
   localparam logic        CSR_SYNC     = 1'b1;
   localparam logic [7:0]  SLAVE_RESET  = 8'h00;
   localparam logic [7:0]  SYNC_RESET   = 8'h05;

   localparam logic [7:0]  CRC_POLY     = 8'h07;
   localparam logic        WRITE_FLAG   = 1'b1;

   // Receive framing: echo bytes, then reply bytes, value starts at reply byte 3.
   localparam logic [3:0]  ECHO_LEN     = 4'd4;
   localparam logic [3:0]  REPLY_LEN    = 4'd8;
   localparam logic [3:0]  VALUE_START  = 4'd3;

   // Last byte index of each outgoing datagram.
   localparam logic [2:0]  WRITE_LAST_IDX = 3'd7;
   localparam logic [2:0]  READ_LAST_IDX  = 3'd3;

   localparam int unsigned QUEUE_DEPTH  = 4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  reg_index;
      logic [31:0] write_value;
      logic [7:0]  rx_byte;
   } urde_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [31:0] read_value;
      logic        read_status;
   } urde_rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_RESULT
   } urde_cmd_kind_type;

   // One unit of work for the datagram sequencer.
   typedef struct packed {
      urde_cmd_kind_type kind;
      logic [6:0]        reg_index;
      logic [31:0]       value;
      logic              status;
   } urde_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } urde_qstat_type;

   // CRC-8, polynomial 0x07, data bits taken LSB first.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                            input logic [7:0] data);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ data[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/urde_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urde_front
// Accepts request beats, tracks reply reception and queues work commands.
// ----------------------------------------------------------------------------
module urde_front
   import urde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire urde_req_type   req_data,
   input  wire urde_qstat_type qstat,
   output logic                push,
   output urde_cmd_type        push_cmd
);

   logic        read_pending_ff, read_pending_in;
   logic [3:0]  rx_count_ff, rx_count_in;
   logic [7:0]  rx_crc_ff, rx_crc_in;
   logic [31:0] reply_shift_ff, reply_shift_in;
   logic        accept;
   logic [3:0]  pos;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign pos       = rx_count_ff - ECHO_LEN;

   always_comb begin
      read_pending_in    = read_pending_ff;
      rx_count_in        = rx_count_ff;
      rx_crc_in          = rx_crc_ff;
      reply_shift_in     = reply_shift_ff;
      push               = 1'b0;
      push_cmd.kind      = CMD_WRITE;
      push_cmd.reg_index = req_data.reg_index;
      push_cmd.value     = req_data.write_value;
      push_cmd.status    = 1'b0;
      if (accept) begin
         case (req_data.req_type)
            REQ_WRITE: begin
               push = 1'b1;
            end
            REQ_READ: begin
               push            = 1'b1;
               push_cmd.kind   = CMD_READ;
               read_pending_in = 1'b1;
               rx_count_in     = '0;
               rx_crc_in       = '0;
               reply_shift_in  = '0;
            end
            REQ_RX: begin
               if (read_pending_ff) begin
                  if (rx_count_ff < ECHO_LEN) begin
                     rx_count_in = rx_count_ff + 4'd1;
                  end else if (pos < REPLY_LEN - 4'd1) begin
                     rx_crc_in   = crc8_feed(rx_crc_ff, req_data.rx_byte);
                     rx_count_in = rx_count_ff + 4'd1;
                     if (pos >= VALUE_START) begin
                        reply_shift_in = {reply_shift_ff[23:0], req_data.rx_byte};
                     end
                  end else begin
                     // Final reply byte is the CRC; the read completes here.
                     push            = 1'b1;
                     push_cmd.kind   = CMD_RESULT;
                     push_cmd.value  = reply_shift_ff;
                     push_cmd.status = (rx_crc_ff != req_data.rx_byte);
                     read_pending_in = 1'b0;
                     rx_count_in     = '0;
                     rx_crc_in       = '0;
                     reply_shift_in  = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pending_ff <= 1'b0;
         rx_count_ff     <= '0;
         rx_crc_ff       <= '0;
         reply_shift_ff  <= '0;
      end else begin
         read_pending_ff <= read_pending_in;
         rx_count_ff     <= rx_count_in;
         rx_crc_ff       <= rx_crc_in;
         reply_shift_ff  <= reply_shift_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/urde_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urde_fifo
// Short command queue between the front and the datagram sequencer.
// ----------------------------------------------------------------------------
module urde_fifo
   import urde_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire urde_cmd_type push_cmd,
   input  wire logic         pop,
   output urde_cmd_type      head,
   output urde_qstat_type    qstat
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   urde_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == DEPTH_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/urde_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urde_back
// Datagram sequencer: commands to result beats, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module urde_back
   import urde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     sync_byte,
   input  wire logic [7:0]     node_addr,
   input  wire urde_cmd_type   head,
   input  wire urde_qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output urde_rsp_type        rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   urde_rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0]   idx_ff, idx_in;
   logic [7:0]   crc_ff, crc_in;
   logic         load, fire, last;
   logic [7:0]   byte_sel;

   assign load = !rsp_valid_ff || rsp_ready;
   assign fire = load && !qstat.empty;
   assign pop  = fire && last;

   always_comb begin
      byte_sel = crc_ff;
      last     = 1'b1;
      case (head.kind)
         CMD_WRITE: begin
            last = (idx_ff == WRITE_LAST_IDX);
            case (idx_ff)
               3'd0:    byte_sel = sync_byte;
               3'd1:    byte_sel = node_addr;
               3'd2:    byte_sel = {WRITE_FLAG, head.reg_index};
               3'd3:    byte_sel = head.value[31:24];
               3'd4:    byte_sel = head.value[23:16];
               3'd5:    byte_sel = head.value[15:8];
               3'd6:    byte_sel = head.value[7:0];
               default: byte_sel = crc_ff;
            endcase
         end
         CMD_READ: begin
            last = (idx_ff == READ_LAST_IDX);
            case (idx_ff)
               3'd0:    byte_sel = sync_byte;
               3'd1:    byte_sel = node_addr;
               3'd2:    byte_sel = {1'b0, head.reg_index};
               default: byte_sel = crc_ff;
            endcase
         end
         default: begin
            byte_sel = '0;
            last     = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      if (load) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         if (head.kind == CMD_RESULT) begin
            rsp_data_in.result_kind = KIND_RESULT;
            rsp_data_in.tx_byte     = '0;
            rsp_data_in.last_byte   = 1'b0;
            rsp_data_in.read_value  = head.value;
            rsp_data_in.read_status = head.status;
         end else begin
            rsp_data_in.result_kind = KIND_TX;
            rsp_data_in.tx_byte     = byte_sel;
            rsp_data_in.last_byte   = last;
            rsp_data_in.read_value  = '0;
            rsp_data_in.read_status = 1'b0;
         end
         if (last) begin
            idx_in = '0;
            crc_in = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
            crc_in = crc8_feed(crc_ff, byte_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         crc_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/uart_register_datagram_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_register_datagram_engine
// Builds and checks CRC-8 protected register datagrams for a single-wire
// UART stepper driver link.
// ----------------------------------------------------------------------------
// A request beat is accepted while the queue has room and, if it makes
// work, lands in a four-entry command queue. The sequencer behind the
// queue sends one result beat per cycle while the output is ready: a write
// request gives eight transmit beats, a read request four, and the last
// received reply byte gives one completed-read beat. The sequencer's
// one-byte-per-cycle walk, stalled while the output is not ready, sets the
// sustained rate. Received-byte beats that complete nothing are absorbed
// by the front and never reach the queue.
module uart_register_datagram_engine
   import urde_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire urde_req_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output urde_rsp_type               rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [7:0]     node_addr_ff;
   logic [7:0]     sync_byte_ff;
   logic           csr_write;
   logic           push, pop;
   urde_cmd_type   push_cmd, head;
   urde_qstat_type qstat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff <= SLAVE_RESET;
         sync_byte_ff <= SYNC_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_SLAVE: node_addr_ff <= csr_pwdata[7:0];
            CSR_SYNC:  sync_byte_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_SLAVE: csr_prdata = {24'd0, node_addr_ff};
         CSR_SYNC:  csr_prdata = {24'd0, sync_byte_ff};
         default:   csr_prdata = '0;
      endcase
   end

   urde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   urde_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   urde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sync_byte (sync_byte_ff),
      .node_addr (node_addr_ff),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The queue can never report full and empty at once.
   assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("command queue full and empty together");

   // The end-of-datagram marker only ever rides on a transmit beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_byte) |-> (rsp_data.result_kind == KIND_TX))
      else $error("last_byte set on a completed-read beat");

   // A completed-read beat carries no transmit byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_RESULT) |-> (rsp_data.tx_byte == 8'd0))
      else $error("completed-read beat carries a transmit byte");

   // Nothing is dequeued when the sequencer cannot hand a beat to the output.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (!qstat.empty && (!rsp_valid || rsp_ready)))
      else $error("command dequeued without an output beat");

endmodule
`default_nettype wire
